>>> rtl/pje_pkg.sv
// ----------------------------------------------------------------------------
// Packet loss and jitter emulator package
// Shared constants, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pje_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TimeBitsDef   = 32;
  localparam int unsigned MaxResults    = 16;

  localparam int unsigned TagW   = 16;
  localparam int unsigned DrawW  = 16;
  localparam int unsigned JitW   = 10;
  localparam int unsigned AgeW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_DROP    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REORDER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_JITTER  = 2'd2;

  // Command codes.
  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Result status codes.
  localparam logic ST_DELIVERED = 1'b0;
  localparam logic ST_LOST      = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUBMIT,
    S_FWD,
    S_FREE,
    S_NEXT,
    S_SCAN,
    S_PICK,
    S_FINISH
  } pje_state_e;

endpackage

>>> rtl/packet_loss_jitter_emulator_core.sv
// ----------------------------------------------------------------------------
// Packet loss and jitter emulator core
// Drops, swaps and delays packet tags; ticks release due packets in deadline
// order from a slot queue, using one shared scan unit under a sequencer.
// ----------------------------------------------------------------------------
// One word is in work at once. A dropped or held submit passes SUBMIT and FINISH;
// a forwarded packet adds FWD and NEXT, and with jitter a free slot search in FREE.
// A tick runs a full scan and a pick per delivered word (at most 16), a closing
// scan unless 16 were delivered, then FINISH; output stalls add on.
// Reset clears time, the held flag, slot valid bits and stamp counter at once.
module packet_loss_jitter_emulator_core
  import pje_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [TagW-1:0]      packet_tag_i,
  input  logic [DrawW-1:0]     rand_drop_i,
  input  logic [DrawW-1:0]     rand_reorder_i,
  input  logic [DrawW-1:0]     rand_delay_first_i,
  input  logic [DrawW-1:0]     rand_delay_second_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TagW-1:0]      out_tag_o,
  output logic                 status_o,
  output logic                 last_o
);

  localparam int unsigned IW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RW    = $clog2(MaxResults + 1);
  localparam int unsigned ProdW = DrawW + JitW + 1;

  pje_state_e state_q, state_d;

  // Configuration.
  logic [DrawW-1:0] drop_thr_q, reorder_thr_q;
  logic [JitW-1:0]  jit_max_q;

  // Architectural state.
  logic [TIME_BITS-1:0]   now_q;
  logic                   held_valid_q;
  logic [TagW-1:0]        held_tag_q;
  logic [QUEUE_DEPTH-1:0] slot_valid_q;
  logic [AgeW-1:0]        insert_cnt_q;

  // Slot contents.
  logic [TagW-1:0]      mem_tag_q [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] mem_dl_q  [QUEUE_DEPTH];
  logic [AgeW-1:0]      mem_age_q [QUEUE_DEPTH];
  logic [TagW-1:0]      rd_tag_q;
  logic [TIME_BITS-1:0] rd_dl_q;
  logic [AgeW-1:0]      rd_age_q;

  // Latched input word and forwarding context.
  logic [TagW-1:0]  in_tag_q;
  logic [DrawW-1:0] rd_q, rr_q, d1_q, d2_q;
  logic [TagW-1:0]  cur_tag_q;
  logic [DrawW-1:0] cur_draw_q;
  logic             second_q;
  logic [ProdW-1:0] prod_q;

  // Scan unit.
  logic [CW-1:0]        iss_cnt_q;
  logic [IW-1:0]        iss_idx;
  logic                 issuing;
  logic                 p1_v_q;
  logic [IW-1:0]        p1_idx_q;
  logic                 p2_v_q;
  logic [IW-1:0]        p2_idx_q;
  logic [TagW-1:0]      p2_tag_q;
  logic [TIME_BITS-1:0] p2_late_q;
  logic [AgeW-1:0]      p2_old_q;
  logic [TIME_BITS-1:0] late;
  logic                 best_found_q;
  logic [IW-1:0]        best_idx_q;
  logic [TagW-1:0]      best_tag_q;
  logic [TIME_BITS-1:0] best_late_q;
  logic [AgeW-1:0]      best_old_q;
  logic                 better;
  logic                 scan_done;
  logic [RW-1:0]        res_cnt_q;

  // Result staging: one pending word so that the last flag can be set late.
  logic            pend_valid_q;
  logic [TagW-1:0] pend_tag_q;
  logic            pend_status_q;
  logic            out_valid_q;
  logic [TagW-1:0] out_tag_q;
  logic            out_status_q;
  logic            out_last_q;

  logic            in_acc, out_free, out_load;
  logic            push_req, push_ok, fin_req, fin_ok;
  logic [TagW-1:0] push_tag;
  logic            push_status;
  logic            drop_hit, hold_hit, jit_zero, slot_free, idx_last;
  logic [JitW:0]   jit_plus1;
  logic [JitW:0]   delay;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign push_ok    = !pend_valid_q || out_free;
  assign fin_ok     = push_ok;
  assign out_load   = pend_valid_q && ((push_req && push_ok) || (fin_req && fin_ok));

  assign drop_hit  = (rd_q < drop_thr_q);
  assign hold_hit  = (rr_q < reorder_thr_q);
  assign jit_zero  = (jit_max_q == '0);
  assign jit_plus1 = {1'b0, jit_max_q} + (JitW+1)'(1);
  assign delay     = prod_q[ProdW-1:DrawW];

  assign iss_idx   = iss_cnt_q[IW-1:0];
  assign issuing   = (state_q == S_SCAN) && (iss_cnt_q != CW'(QUEUE_DEPTH));
  assign scan_done = !issuing && !p1_v_q && !p2_v_q;
  assign slot_free = !slot_valid_q[iss_idx];
  assign idx_last  = (iss_cnt_q == CW'(QUEUE_DEPTH - 1));
  assign late      = now_q - rd_dl_q;

  // Older entry wins a tie on lateness.
  assign better = !best_found_q || (p2_late_q > best_late_q) ||
                  ((p2_late_q == best_late_q) && (p2_old_q > best_old_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = (cmd_i == CMD_TICK) ? S_SCAN : S_SUBMIT;
      end
      S_SUBMIT: begin
        priority if (drop_hit)     state_d = S_FINISH;
        else if (held_valid_q)     state_d = S_FWD;
        else if (hold_hit)         state_d = S_FINISH;
        else                       state_d = S_FWD;
      end
      S_FWD: begin
        if (!jit_zero)    state_d = S_FREE;
        else if (push_ok) state_d = S_NEXT;
      end
      S_FREE: begin
        if (slot_free)                 state_d = S_NEXT;
        else if (idx_last && push_ok)  state_d = S_NEXT;
      end
      S_NEXT: begin
        state_d = second_q ? S_FWD : S_FINISH;
      end
      S_SCAN: begin
        if (scan_done) state_d = S_PICK;
      end
      S_PICK: begin
        if (!best_found_q) state_d = S_FINISH;
        else if (push_ok)  state_d = (res_cnt_q == RW'(MaxResults - 1)) ? S_FINISH : S_SCAN;
      end
      S_FINISH: begin
        if (fin_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    push_req    = 1'b0;
    push_tag    = cur_tag_q;
    push_status = ST_DELIVERED;
    fin_req     = 1'b0;
    unique case (state_q)
      S_FWD:    push_req = jit_zero;
      S_FREE: begin
        push_req    = !slot_free && idx_last;
        push_status = ST_LOST;
      end
      S_PICK: begin
        push_req = best_found_q;
        push_tag = best_tag_q;
      end
      S_FINISH: fin_req = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_thr_q    <= '0;
      reorder_thr_q <= '0;
      jit_max_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DROP:    drop_thr_q    <= cfg_data_i;
        CFG_REORDER: reorder_thr_q <= cfg_data_i;
        CFG_JITTER:  jit_max_q     <= cfg_data_i[JitW-1:0];
        default: ;
      endcase
    end
  end

  // Slot storage, written during the free slot search and read by the scan.
  always_ff @(posedge clk_i) begin
    if (state_q == S_FREE && slot_free) begin
      mem_tag_q[iss_idx] <= cur_tag_q;
      mem_dl_q[iss_idx]  <= now_q + TIME_BITS'(delay);
      mem_age_q[iss_idx] <= insert_cnt_q;
    end
    rd_tag_q <= mem_tag_q[iss_idx];
    rd_dl_q  <= mem_dl_q[iss_idx];
    rd_age_q <= mem_age_q[iss_idx];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      held_valid_q <= 1'b0;
      slot_valid_q <= '0;
      insert_cnt_q <= '0;
      second_q     <= 1'b0;
      iss_cnt_q    <= '0;
      p1_v_q       <= 1'b0;
      p2_v_q       <= 1'b0;
      best_found_q <= 1'b0;
      res_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && cmd_i == CMD_TICK) begin
            now_q        <= now_q + TIME_BITS'(1);
            iss_cnt_q    <= '0;
            best_found_q <= 1'b0;
            res_cnt_q    <= '0;
          end
        end
        S_SUBMIT: begin
          priority if (drop_hit) begin
          end else if (held_valid_q) begin
            held_valid_q <= 1'b0;
            second_q     <= 1'b1;
          end else if (hold_hit) begin
            held_valid_q <= 1'b1;
          end else begin
            second_q <= 1'b0;
          end
        end
        S_FWD: begin
          iss_cnt_q <= '0;
        end
        S_FREE: begin
          if (slot_free) begin
            slot_valid_q[iss_idx] <= 1'b1;
            insert_cnt_q          <= insert_cnt_q + AgeW'(1);
          end else if (!idx_last) begin
            iss_cnt_q <= iss_cnt_q + CW'(1);
          end
        end
        S_NEXT: begin
          second_q <= 1'b0;
        end
        S_SCAN: begin
          if (issuing) iss_cnt_q <= iss_cnt_q + CW'(1);
          if (p2_v_q && better) best_found_q <= 1'b1;
        end
        S_PICK: begin
          if (best_found_q && push_ok) begin
            slot_valid_q[best_idx_q] <= 1'b0;
            res_cnt_q                <= res_cnt_q + RW'(1);
            iss_cnt_q                <= '0;
            best_found_q             <= 1'b0;
          end
        end
        default: ;
      endcase

      // Scan pipeline: read, lateness, compare.
      p1_v_q <= issuing && slot_valid_q[iss_idx];
      p2_v_q <= p1_v_q && !late[TIME_BITS-1];

      // Result staging.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (push_req && push_ok) begin
        pend_valid_q <= 1'b1;
      end else if (fin_req && fin_ok && pend_valid_q) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_tag_q <= packet_tag_i;
      rd_q     <= rand_drop_i;
      rr_q     <= rand_reorder_i;
      d1_q     <= rand_delay_first_i;
      d2_q     <= rand_delay_second_i;
    end
    if (state_q == S_SUBMIT) begin
      cur_tag_q  <= in_tag_q;
      cur_draw_q <= d1_q;
      if (!drop_hit && !held_valid_q && hold_hit) held_tag_q <= in_tag_q;
    end
    if (state_q == S_NEXT && second_q) begin
      cur_tag_q  <= held_tag_q;
      cur_draw_q <= d2_q;
    end
    if (state_q == S_FWD) begin
      prod_q <= ProdW'(cur_draw_q) * ProdW'(jit_plus1);
    end

    p1_idx_q  <= iss_idx;
    p2_idx_q  <= p1_idx_q;
    p2_tag_q  <= rd_tag_q;
    p2_late_q <= late;
    p2_old_q  <= insert_cnt_q - rd_age_q;
    if (state_q == S_SCAN && p2_v_q && better) begin
      best_idx_q  <= p2_idx_q;
      best_tag_q  <= p2_tag_q;
      best_late_q <= p2_late_q;
      best_old_q  <= p2_old_q;
    end

    if (push_req && push_ok) begin
      if (pend_valid_q) begin
        out_tag_q    <= pend_tag_q;
        out_status_q <= pend_status_q;
        out_last_q   <= 1'b0;
      end
      pend_tag_q    <= push_tag;
      pend_status_q <= push_status;
    end else if (fin_req && fin_ok && pend_valid_q) begin
      out_tag_q    <= pend_tag_q;
      out_status_q <= pend_status_q;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tag_o   = out_tag_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule
